// ----- hw/rtl/rcl_pkg.sv -----
// ----------------------------------------------------------------------------
// rcl_pkg
// Shared types and constants of the raster cluster labeling core.
// ----------------------------------------------------------------------------
package rcl_pkg;

  localparam int unsigned LabelW    = 12;
  localparam int unsigned MaxLabels = 4096;
  localparam int unsigned ColW      = 10;
  localparam int unsigned RowW      = 10;
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned CfgW      = 11;

  localparam logic [LabelW-1:0] TopLabel = LabelW'(MaxLabels - 1);

  // Item kinds carried in the input tuser.
  typedef enum logic [1:0] {
    OP_PIXEL   = 2'd0,
    OP_RESOLVE = 2'd1,
    OP_FRAME   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_TERRACE_ROWS  = 2'd1,
    REG_TERRACE_COUNT = 2'd2,
    REG_BOND_ACROSS   = 2'd3
  } reg_e;

  // Status of the terrace-start test for the current row.
  typedef struct packed {
    logic valid;
    logic start_row;
  } step_flag_t;

endpackage

// ----- hw/rtl/raster_cluster_labeling_core.sv -----
// ----------------------------------------------------------------------------
// raster_cluster_labeling_core
// First labeling pass over a raster with a union-find link table in memory.
// ----------------------------------------------------------------------------
//  channel  | direction | beat contents
//  s_axis   | in        | tuser: op; tdata: occupied, label_query
//  m_axis   | out       | tuser: label_overflow; tdata: pixel_label, root_label
//  cfg      | in        | register index and 11-bit data, always ready
//
//  One item at a time. A resolve walks the link table one hop at a time; an
//  unallocated label or an empty pixel completes at once. A new label reads
//  the neighbors first; a merging pixel also walks each to its root. After
//  reset and each start-frame beat the row buffer is swept; a row change or
//  config write reruns the terrace test, and no item is taken until it ends.
//  A held result stalls the next item only at its completion step.
// ----------------------------------------------------------------------------
module raster_cluster_labeling_core
  import rcl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // occupied, label_query, pad
  input  logic [1:0]        s_axis_tuser,   // op
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // pixel_label, root_label
  output logic              m_axis_tuser,   // label_overflow
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [CfgW-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_TOP, ST_TR, ST_SEL, ST_FIND, ST_LINK, ST_DONE
  } state_e;

  state_e            state_q, state_d;
  op_e               kind_q, kind_d;
  logic [ColW-1:0]   clr_q, clr_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [LabelW-1:0] left_q, left_d;
  logic [LabelW-1:0] next_q, next_d;
  logic [LabelW-1:0] nbr_q [3];
  logic [LabelW-1:0] nbr_d [3];
  logic [LabelW-1:0] root_q [3];
  logic [LabelW-1:0] root_d [3];
  logic [2:0]        rvld_q, rvld_d;
  logic [1:0]        slot_q, slot_d;
  logic [LabelW-1:0] x_q, x_d;
  logic [LabelW-1:0] lab_q, lab_d;
  logic              ovf_q, ovf_d;
  logic [LabelW-1:0] res_q, res_d;
  logic              out_vld_q;
  logic [23:0]       out_data_q;
  logic              out_ovf_q;

  logic [CfgW-1:0]   fw_q, tr_q;
  logic [RowW-1:0]   tc_q;
  logic              bond_q;

  // Link table and row buffer.
  logic [LabelW-1:0] link_mem [MaxLabels];
  logic [LabelW-1:0] row_mem [MaxWidth];
  logic [LabelW-1:0] link_rdata_q, row_rdata_q;
  logic [LabelW-1:0] link_raddr, link_waddr, link_wdata;
  logic              link_we;
  logic [ColW-1:0]   row_raddr, row_waddr;
  logic [LabelW-1:0] row_wdata;
  logic              row_we;

  logic              accept, finish, restart, cut;
  logic [CfgW-1:0]   w_eff;
  logic [CfgW-1:0]   col_next;
  logic              right_ok, row_end;
  logic [LabelW-1:0] nr_now, min_root;
  logic [LabelW-1:0] query;
  step_flag_t        step;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= CfgW'(MaxWidth);
      tr_q   <= CfgW'(1024);
      tc_q   <= '0;
      bond_q <= 1'b0;
    end else if (cfg_valid) begin
      unique case (reg_e'(cfg_index))
        REG_FRAME_WIDTH:   fw_q   <= cfg_data;
        REG_TERRACE_ROWS:  tr_q   <= cfg_data;
        REG_TERRACE_COUNT: tc_q   <= cfg_data[RowW-1:0];
        REG_BOND_ACROSS:   bond_q <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  // Terrace-start test for the current row.
  rcl_step_div u_step_div (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .restart_i       (restart),
    .row_i           (row_q),
    .terrace_rows_i  (tr_q),
    .terrace_count_i (tc_q),
    .step_o          (step)
  );

  // Effective row width and row edge tests.
  always_comb begin
    if (fw_q == '0) begin
      w_eff = CfgW'(1);
    end else if (fw_q > CfgW'(MaxWidth)) begin
      w_eff = CfgW'(MaxWidth);
    end else begin
      w_eff = fw_q;
    end
  end
  assign col_next = {1'b0, col_q} + CfgW'(1);
  assign right_ok = col_next < w_eff;
  assign row_end  = !right_ok;
  assign cut      = step.start_row && !bond_q;
  assign nr_now   = (cut || !right_ok) ? '0 : row_rdata_q;
  assign query    = s_axis_tdata[LabelW:1];

  assign s_axis_tready = (state_q == ST_IDLE) && step.valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign finish        = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready);

  // Smallest valid root.
  always_comb begin
    min_root = TopLabel;
    for (int i = 0; i < 3; i++) begin
      if (rvld_q[i] && root_q[i] < min_root) min_root = root_q[i];
    end
  end

  // Sequencer: row buffer sweep, neighbor reads, root walks, link writes, completion.
  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    clr_d      = clr_q;
    col_d      = col_q;
    row_d      = row_q;
    left_d     = left_q;
    next_d     = next_q;
    nbr_d      = nbr_q;
    root_d     = root_q;
    rvld_d     = rvld_q;
    slot_d     = slot_q;
    x_d        = x_q;
    lab_d      = lab_q;
    ovf_d      = ovf_q;
    res_d      = res_q;
    restart    = cfg_valid;
    link_raddr = x_q;
    link_we    = 1'b0;
    link_waddr = root_q[slot_q];
    link_wdata = lab_q;
    row_raddr  = col_q;
    row_we     = 1'b0;
    row_waddr  = col_q;
    row_wdata  = lab_q;
    unique case (state_q)
      ST_CLEAR: begin
        row_we    = 1'b1;
        row_waddr = clr_q;
        row_wdata = '0;
        clr_d     = clr_q + ColW'(1);
        if (clr_q == ColW'(MaxWidth - 1)) begin
          state_d = (kind_q == OP_FRAME) ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          kind_d = op_e'(s_axis_tuser);
          lab_d  = '0;
          ovf_d  = 1'b0;
          res_d  = '0;
          unique case (op_e'(s_axis_tuser))
            OP_PIXEL: begin
              state_d = s_axis_tdata[0] ? ST_TOP : ST_DONE;
            end
            OP_RESOLVE: begin
              if (query != '0 && query <= next_q) begin
                x_d        = query;
                link_raddr = query;
                state_d    = ST_FIND;
              end else begin
                state_d = ST_DONE;
              end
            end
            OP_FRAME: begin
              clr_d   = '0;
              col_d   = '0;
              row_d   = '0;
              left_d  = '0;
              next_d  = '0;
              restart = 1'b1;
              state_d = ST_CLEAR;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_TOP: begin
        nbr_d[0]  = left_q;
        nbr_d[1]  = cut ? '0 : row_rdata_q;
        row_raddr = col_next[ColW-1:0];
        state_d   = ST_TR;
      end
      ST_TR: begin
        nbr_d[2] = nr_now;
        slot_d   = '0;
        if (nbr_q[0] == '0 && nbr_q[1] == '0 && nr_now == '0) begin
          if (next_q == TopLabel) begin
            lab_d = TopLabel;
            ovf_d = 1'b1;
          end else begin
            next_d     = next_q + LabelW'(1);
            lab_d      = next_d;
            link_we    = 1'b1;
            link_waddr = next_d;
            link_wdata = next_d;
          end
          state_d = ST_DONE;
        end else begin
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        if (nbr_q[slot_q] == '0) begin
          rvld_d[slot_q] = 1'b0;
          slot_d         = slot_q + 2'd1;
          if (slot_q == 2'd2) begin
            state_d = ST_LINK;
            slot_d  = '0;
          end
        end else begin
          x_d        = nbr_q[slot_q];
          link_raddr = nbr_q[slot_q];
          state_d    = ST_FIND;
        end
      end
      ST_FIND: begin
        // One hop per cycle until an entry points at itself.
        if (link_rdata_q == x_q) begin
          if (kind_q == OP_RESOLVE) begin
            res_d   = x_q;
            state_d = ST_DONE;
          end else begin
            root_d[slot_q] = x_q;
            rvld_d[slot_q] = 1'b1;
            slot_d         = slot_q + 2'd1;
            state_d        = ST_SEL;
            if (slot_q == 2'd2) begin
              state_d = ST_LINK;
              slot_d  = '0;
            end
          end
        end else begin
          x_d        = link_rdata_q;
          link_raddr = link_rdata_q;
        end
      end
      ST_LINK: begin
        lab_d      = min_root;
        link_wdata = min_root;
        link_we    = rvld_q[slot_q] && (root_q[slot_q] > min_root);
        slot_d     = slot_q + 2'd1;
        if (slot_q == 2'd2) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (finish) begin
          state_d = ST_IDLE;
          if (kind_q == OP_PIXEL) begin
            row_we = 1'b1;
            left_d = lab_q;
            col_d  = col_next[ColW-1:0];
            if (row_end) begin
              col_d   = '0;
              left_d  = '0;
              row_d   = row_q + RowW'(1);
              restart = 1'b1;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      kind_q  <= OP_NONE;
      clr_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      left_q  <= '0;
      next_q  <= '0;
      slot_q  <= '0;
      rvld_q  <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      clr_q   <= clr_d;
      col_q   <= col_d;
      row_q   <= row_d;
      left_q  <= left_d;
      next_q  <= next_d;
      slot_q  <= slot_d;
      rvld_q  <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nbr_q  <= nbr_d;
    root_q <= root_d;
    x_q    <= x_d;
    lab_q  <= lab_d;
    ovf_q  <= ovf_d;
    res_q  <= res_d;
  end

  // Memories: one write and one registered read each per cycle.
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    link_rdata_q <= link_mem[link_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[row_waddr] <= row_wdata;
    row_rdata_q <= row_mem[row_raddr];
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (finish) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_data_q <= {res_q, lab_q};
      out_ovf_q  <= ovf_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ovf_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == ST_IDLE) && step.valid)
    else $error("input ready outside idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[LabelW-1:0] == TopLabel))
    else $error("overflow without saturated label");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (link_we && state_q == ST_LINK) |-> (link_wdata < link_waddr))
    else $error("link written toward a larger root");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIND) |-> (x_q != '0))
    else $error("root walk on label zero");

endmodule

// ----- hw/rtl/rcl_step_div.sv -----
// ----------------------------------------------------------------------------
// rcl_step_div
// Bit-serial divider that decides whether the current row starts a terrace.
// ----------------------------------------------------------------------------
module rcl_step_div
  import rcl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                restart_i,
  input  logic [RowW-1:0]     row_i,
  input  logic [CfgW-1:0]     terrace_rows_i,
  input  logic [RowW-1:0]     terrace_count_i,
  output step_flag_t          step_o
);

  logic            active_q, active_d;
  logic            vld_q, vld_d;
  logic            start_q, start_d;
  logic [3:0]      cnt_q, cnt_d;
  logic [CfgW-1:0] rem_q, rem_d;
  logic [RowW-1:0] quo_q, quo_d;
  logic [3:0]      bit_idx;
  logic [CfgW:0]   trial;

  assign bit_idx = cnt_q - 4'd1;
  assign trial   = {rem_q, row_i[bit_idx]};

  // One quotient bit per cycle; the flag is formed on the last step.
  always_comb begin
    active_d = active_q;
    vld_d    = vld_q;
    start_d  = start_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    if (restart_i) begin
      vld_d    = 1'b0;
      active_d = 1'b0;
    end else if (!vld_q && !active_q) begin
      active_d = 1'b1;
      cnt_d    = 4'(RowW);
      rem_d    = '0;
      quo_d    = '0;
    end else if (active_q) begin
      if (trial >= {1'b0, terrace_rows_i}) begin
        rem_d = CfgW'(trial - {1'b0, terrace_rows_i});
        quo_d = {quo_q[RowW-2:0], 1'b1};
      end else begin
        rem_d = trial[CfgW-1:0];
        quo_d = {quo_q[RowW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd1) begin
        active_d = 1'b0;
        vld_d    = 1'b1;
        if (terrace_count_i == '0) begin
          start_d = 1'b0;
        end else if (terrace_rows_i == '0) begin
          start_d = (row_i == '0);
        end else begin
          start_d = (rem_d == '0) && (quo_d < terrace_count_i);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      vld_q    <= 1'b0;
      start_q  <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      vld_q    <= vld_d;
      start_q  <= start_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign step_o.valid     = vld_q;
  assign step_o.start_row = start_q;

  // The flag only turns valid at the end of a division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vld_q) |-> $past(active_q))
    else $error("terrace flag valid without a division");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> !vld_q)
    else $error("divider active while flag valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_i |=> !vld_q)
    else $error("flag survived a restart");

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for raster_cluster_labeling_core. A predictor of the
// labeling pass runs beside the core and every output beat is compared,
// field by field, with the oldest predicted result. The tests cover neighbor
// merges, terrace step bonds, a width change in mid-row and random pixel
// streams under several register settings.
// ----------------------------------------------------------------------------
module tb;
  import rcl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One predicted output beat.
  typedef struct {
    logic [LabelW-1:0] pixel_label;
    logic [LabelW-1:0] root_label;
    logic              overflow;
  } label_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;
  logic [1:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;
  logic              m_axis_tuser;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [CfgW-1:0]   cfg_data = '0;

  raster_cluster_labeling_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Shadow copy of the labeling state and registers.
  logic [LabelW-1:0] link_tab [MaxLabels];
  logic [LabelW-1:0] row_above [MaxWidth];
  logic [LabelW-1:0] left_lab;
  logic [LabelW-1:0] last_lab;
  int unsigned       scan_col;
  int unsigned       scan_row;
  int unsigned       width_reg;
  int unsigned       trows_reg;
  int unsigned       tcount_reg;
  bit                bond_reg;

  label_result_t pending_labels [$];
  int            error_count = 0;
  bit            quiet = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb: done, errors");
    $finish;
  end

  function automatic int unsigned root_of(int unsigned lab);
    int unsigned nxt;
    for (int i = 0; i < MaxLabels; i++) begin
      nxt = link_tab[lab];
      if (nxt == lab) break;
      lab = nxt;
    end
    return lab;
  endfunction

  function automatic void clear_scan();
    foreach (row_above[i]) row_above[i] = '0;
    left_lab = '0;
    last_lab = '0;
    scan_col = 0;
    scan_row = 0;
  endfunction

  function automatic bit step_row(int unsigned r);
    if (tcount_reg == 0) return 1'b0;
    if (trows_reg == 0) return r == 0;
    return (r % trows_reg) == 0 && (r / trows_reg) < tcount_reg;
  endfunction

  // Labels one pixel and advances the scan position.
  function automatic label_result_t label_pixel(bit occ);
    label_result_t res;
    int unsigned w, nl, nt, nr, rl, rt, rr, m;
    res = '{default: '0};
    w = (width_reg == 0) ? 1 : (width_reg > MaxWidth ? MaxWidth : width_reg);
    if (occ) begin
      nl = left_lab;
      nt = row_above[scan_col];
      nr = (scan_col + 1 < w) ? row_above[scan_col + 1] : 0;
      if (step_row(scan_row) && !bond_reg) begin
        nt = 0;
        nr = 0;
      end
      if (nl == 0 && nt == 0 && nr == 0) begin
        if (last_lab >= TopLabel) begin
          res.pixel_label = TopLabel;
          res.overflow = 1'b1;
        end else begin
          last_lab++;
          res.pixel_label = last_lab;
          link_tab[last_lab] = last_lab;
        end
      end else begin
        rl = nl ? root_of(nl) : MaxLabels;
        rt = nt ? root_of(nt) : MaxLabels;
        rr = nr ? root_of(nr) : MaxLabels;
        m = rl;
        if (rt < m) m = rt;
        if (rr < m) m = rr;
        res.pixel_label = LabelW'(m);
        if (rl < MaxLabels && rl > m) link_tab[rl] = LabelW'(m);
        if (rt < MaxLabels && rt > m) link_tab[rt] = LabelW'(m);
        if (rr < MaxLabels && rr > m) link_tab[rr] = LabelW'(m);
      end
    end
    row_above[scan_col] = res.pixel_label;
    left_lab = res.pixel_label;
    scan_col++;
    if (scan_col >= w) begin
      scan_col = 0;
      left_lab = '0;
      scan_row = (scan_row + 1) % 1024;
    end
    return res;
  endfunction

  function automatic label_result_t predict_item(op_e op, bit occ, int unsigned q);
    label_result_t res;
    res = '{default: '0};
    case (op)
      OP_PIXEL: begin
        res = label_pixel(occ);
      end
      OP_RESOLVE: begin
        if (q != 0 && q <= last_lab) res.root_label = LabelW'(root_of(q));
      end
      OP_FRAME: begin
        clear_scan();
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Sends one input beat and records the predicted result.
  task automatic send_item(op_e op, bit occ, int unsigned q);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, q[LabelW-1:0], occ};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_labels.push_back(predict_item(op, occ, q));
  endtask

  // Waits for all results, then for the core to finish its row sweep.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_labels.size() != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CfgW-1:0];
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:   width_reg  = value & 11'h7FF;
      REG_TERRACE_ROWS:  trows_reg  = value & 11'h7FF;
      REG_TERRACE_COUNT: tcount_reg = value & 10'h3FF;
      default:           bond_reg   = value[0];
    endcase
  endtask

  task automatic set_regs(int unsigned w, int unsigned tr, int unsigned tc, bit bond);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_TERRACE_ROWS, tr);
    write_reg(REG_TERRACE_COUNT, tc);
    write_reg(REG_BOND_ACROSS, bond);
  endtask

  // Output side: random stalls, then compare one beat with the oldest prediction.
  initial begin
    label_result_t want;
    int unsigned   gap;
    @(posedge rst_ni);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (pending_labels.size() == 0) begin
        $error("unexpected result beat");
        error_count++;
      end else begin
        want = pending_labels.pop_front();
        if (m_axis_tdata[11:0] !== want.pixel_label) begin
          $error("pixel_label: expected %0d, got %0d", want.pixel_label, m_axis_tdata[11:0]);
          error_count++;
        end
        if (m_axis_tdata[23:12] !== want.root_label) begin
          $error("root_label: expected %0d, got %0d", want.root_label, m_axis_tdata[23:12]);
          error_count++;
        end
        if (m_axis_tuser !== want.overflow) begin
          $error("label_overflow: expected %0d, got %0d", want.overflow, m_axis_tuser);
          error_count++;
        end
      end
    end
  end

  // Small shapes: new labels, merges through left, top and top-right, resolves.
  task automatic test_merges();
    set_regs(3, 1, 1, 1'b0);
    send_item(OP_FRAME, 1'b1, 12'hFFF);
    send_item(OP_PIXEL, 1'b1, 0);
    send_item(OP_PIXEL, 1'b0, 0);
    send_item(OP_PIXEL, 1'b1, 0);
    send_item(OP_PIXEL, 1'b0, 0);
    send_item(OP_PIXEL, 1'b1, 0);
    send_item(OP_PIXEL, 1'b1, 0);
    send_item(OP_PIXEL, 1'b1, 0);
    send_item(OP_PIXEL, 1'b0, 0);
    send_item(OP_PIXEL, 1'b1, 0);
    send_item(OP_RESOLVE, 1'b0, 0);
    send_item(OP_RESOLVE, 1'b0, 2);
    send_item(OP_RESOLVE, 1'b1, 3);
    send_item(OP_RESOLVE, 1'b0, 4095);
    send_item(OP_NONE, 1'b1, 12'hABC);
    drain();
  endtask

  // Step rows cut top bonds unless bonding across steps is enabled.
  task automatic test_terraces();
    for (int b = 0; b < 2; b++) begin
      set_regs(2, 2, 2, b[0]);
      send_item(OP_FRAME, 1'b0, 0);
      repeat (8) send_item(OP_PIXEL, 1'b1, 0);
      send_item(OP_RESOLVE, 1'b0, 2);
      drain();
    end
  endtask

  // Narrowing the row in mid-row still processes the next pixel, then wraps.
  task automatic test_width_change();
    set_regs(4, 1024, 0, 1'b0);
    send_item(OP_FRAME, 1'b0, 0);
    send_item(OP_PIXEL, 1'b1, 0);
    send_item(OP_PIXEL, 1'b0, 0);
    drain();
    write_reg(REG_FRAME_WIDTH, 1);
    send_item(OP_PIXEL, 1'b1, 0);
    send_item(OP_PIXEL, 1'b1, 0);
    drain();
  endtask

  // Random stream under one register setting.
  task automatic random_phase(int unsigned n, int unsigned w, int unsigned tr,
                              int unsigned tc, bit bond);
    int unsigned pick, q;
    set_regs(w, tr, tc, bond);
    send_item(OP_FRAME, $urandom_range(0, 1), $urandom_range(0, 4095));
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      q = $urandom_range(0, 4095);
      if (i % 200 == 100) quiet = ~quiet;
      if (pick < 85) begin
        send_item(OP_PIXEL, $urandom_range(0, 2) != 0, q);
      end else if (pick < 94) begin
        case ($urandom_range(0, 3))
          0, 1: q = (last_lab == 0) ? 0 : $urandom_range(1, last_lab);
          2:    q = (last_lab + 1) & 12'hFFF;
          default: begin
          end
        endcase
        send_item(OP_RESOLVE, $urandom_range(0, 1), q);
      end else if (pick < 97) begin
        send_item(OP_FRAME, $urandom_range(0, 1), q);
      end else begin
        send_item(OP_NONE, $urandom_range(0, 1), q);
      end
    end
    quiet = 1'b0;
    drain();
  endtask

  task automatic test_random();
    random_phase(1040, 1024, 1024, 0, 1'b0);
    random_phase(150, 1, 1, 512, 1'b1);
    for (int k = 0; k < 3; k++) begin
      random_phase(160, $urandom_range(2, 16), $urandom_range(1, 4),
                   $urandom_range(0, 3), $urandom_range(0, 1));
    end
  endtask

  initial begin
    foreach (link_tab[i]) link_tab[i] = '0;
    clear_scan();
    width_reg  = 1024;
    trows_reg  = 1024;
    tcount_reg = 0;
    bond_reg   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (1100) @(posedge clk_i);
    test_merges();
    test_terraces();
    test_width_change();
    test_random();
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
